// ===== src/pdd_pkg.sv =====
// Shared constants, types and widths of the path distance downsampler.
package pdd_pkg;

  localparam int COORD_BITS   = 24;
  localparam int SPACING_BITS = 20;
  localparam int TRAVEL_BITS  = 40;
  localparam int SQ_BITS      = 2 * COORD_BITS;
  localparam int RAD_BITS     = SQ_BITS + 1;
  localparam int ROOT_BITS    = COORD_BITS + 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SPACING_BITS-1:0] SPACING_RESET = SPACING_BITS'(410);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        delta_t;
  typedef logic [SPACING_BITS-1:0]      spacing_t;

  // One classified point as it travels from the front to the back.
  typedef struct packed {
    coord_t x;
    coord_t y;
    delta_t dx;
    delta_t dy;
    logic   first;
    logic   last;
  } pdd_item_t;

  // Fill status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } pdd_qstat_t;

endpackage

// ===== src/pdd_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
module pdd_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pdd_pkg::RAD_BITS-1:0] radicand_i,
  output logic                         done_o,
  output logic [pdd_pkg::ROOT_BITS-1:0] root_o
);
  import pdd_pkg::*;

  localparam int RADP_BITS = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int CNT_BITS  = $clog2(ROOT_BITS);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic [RADP_BITS-1:0] rad_q;
  logic [REM_BITS-1:0]  rem_q;
  logic [ROOT_BITS-1:0] root_q;

  logic [REM_BITS+1:0]  shifted;
  logic [REM_BITS+1:0]  trial;
  logic [REM_BITS+1:0]  diff;
  logic                 ge;

  // Bring down the next two radicand bits and try to append a one to the root.
  always_comb begin
    shifted = {rem_q, rad_q[RADP_BITS-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    ge      = (shifted >= trial);
    diff    = shifted - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(ROOT_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {{(RADP_BITS - RAD_BITS){1'b0}}, radicand_i};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RADP_BITS-3:0], 2'b00};
      rem_q  <= ge ? diff[REM_BITS-1:0] : shifted[REM_BITS-1:0];
      root_q <= {root_q[ROOT_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("square root restarted while busy");

endmodule

// ===== src/pdd_fifo.sv =====
// Short queue of classified points between the front and the back.
module pdd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pdd_pkg::pdd_item_t    wdata_i,
  input  logic                  pop_i,
  output pdd_pkg::pdd_item_t    rdata_o,
  output pdd_pkg::pdd_qstat_t   stat_o
);
  import pdd_pkg::*;

  pdd_item_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr_q;
  logic [QPTR_BITS-1:0] rptr_q;
  logic [QCNT_BITS-1:0] cnt_q;

  function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
    ptr_next = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && stat_o.full) |-> pop_i)
    else $error("queue written while full");

endmodule

// ===== src/pdd_front.sv =====
// Front end: takes points, forms the coordinate deltas and queues them.
module pdd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pdd_pkg::coord_t     pos_x_i,
  input  pdd_pkg::coord_t     pos_y_i,
  input  logic                first_point_i,
  input  logic                last_point_i,
  input  pdd_pkg::pdd_qstat_t qstat_i,
  output logic                push_o,
  output pdd_pkg::pdd_item_t  item_o
);
  import pdd_pkg::*;

  coord_t                prev_x_q;
  coord_t                prev_y_q;
  logic [COORD_BITS:0]   dx_s;
  logic [COORD_BITS:0]   dy_s;
  logic [COORD_BITS:0]   dx_abs;
  logic [COORD_BITS:0]   dy_abs;
  logic                  accept;

  // The largest delta is 2^COORD_BITS - 1, so the magnitude fits in COORD_BITS bits.
  always_comb begin
    dx_s   = {pos_x_i[COORD_BITS-1], pos_x_i} - {prev_x_q[COORD_BITS-1], prev_x_q};
    dy_s   = {pos_y_i[COORD_BITS-1], pos_y_i} - {prev_y_q[COORD_BITS-1], prev_y_q};
    dx_abs = dx_s[COORD_BITS] ? -dx_s : dx_s;
    dy_abs = dy_s[COORD_BITS] ? -dy_s : dy_s;
  end

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign push_o     = accept;

  always_comb begin
    item_o.x     = pos_x_i;
    item_o.y     = pos_y_i;
    item_o.dx    = dx_abs[COORD_BITS-1:0];
    item_o.dy    = dy_abs[COORD_BITS-1:0];
    item_o.first = first_point_i;
    item_o.last  = last_point_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (accept) begin
      prev_x_q <= pos_x_i;
      prev_y_q <= pos_y_i;
    end
  end

endmodule

// ===== src/pdd_back.sv =====
// Back end: distance, accumulation, spacing test and result emission.
module pdd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdd_pkg::pdd_qstat_t qstat_i,
  input  pdd_pkg::pdd_item_t  item_i,
  output logic                pop_o,
  input  pdd_pkg::spacing_t   spacing_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pdd_pkg::coord_t     out_x_o,
  output pdd_pkg::coord_t     out_y_o,
  output logic                out_end_o
);
  import pdd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQUARE = 8'b0000_0010,
    S_START  = 8'b0000_0100,
    S_ROOT   = 8'b0000_1000,
    S_ADD    = 8'b0001_0000,
    S_CMP    = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_CLOSE  = 8'b1000_0000
  } pdd_state_e;

  pdd_state_e             state_q, state_d;
  pdd_item_t              cur_q;
  logic [SQ_BITS-1:0]     sq_x_q;
  logic [SQ_BITS-1:0]     sq_y_q;
  logic [ROOT_BITS-1:0]   dist_q;
  logic [TRAVEL_BITS-1:0] travelled_q, travelled_d;
  logic                   out_valid_q;
  coord_t                 out_x_q;
  coord_t                 out_y_q;
  logic                   out_end_q;

  logic                   out_free;
  logic                   out_load;
  logic                   out_end_load;
  logic                   root_start;
  logic                   root_done;
  logic [ROOT_BITS-1:0]   root;
  logic [RAD_BITS-1:0]    radicand;
  logic [TRAVEL_BITS:0]   acc_sum;
  logic                   take;

  assign radicand = RAD_BITS'(sq_x_q) + RAD_BITS'(sq_y_q);
  assign acc_sum  = {1'b0, travelled_q} + (TRAVEL_BITS + 1)'(dist_q);
  assign take     = (travelled_q >= TRAVEL_BITS'(spacing_i));
  assign out_free = !out_valid_q || !out_stall_i;

  pdd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (radicand),
    .done_o     (root_done),
    .root_o     (root)
  );

  always_comb begin
    state_d      = state_q;
    travelled_d  = travelled_q;
    pop_o        = 1'b0;
    root_start   = 1'b0;
    out_load     = 1'b0;
    out_end_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          if (item_i.first) begin
            travelled_d = '0;
            state_d     = S_EMIT;
          end else begin
            state_d = S_SQUARE;
          end
        end
      end
      S_SQUARE: state_d = S_START;
      S_START: begin
        root_start = 1'b1;
        state_d    = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        travelled_d = acc_sum[TRAVEL_BITS] ? '1 : acc_sum[TRAVEL_BITS-1:0];
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (take) begin
          travelled_d = travelled_q - TRAVEL_BITS'(spacing_i);
          state_d     = S_EMIT;
        end else if (cur_q.last) begin
          state_d = S_CLOSE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = cur_q.last ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_end_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      travelled_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      travelled_q <= travelled_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
    if (state_q == S_SQUARE) begin
      sq_x_q <= cur_q.dx * cur_q.dx;
      sq_y_q <= cur_q.dy * cur_q.dy;
    end
    if (state_q == S_ROOT && root_done) begin
      dist_q <= root;
    end
    if (out_load) begin
      out_x_q   <= cur_q.x;
      out_y_q   <= cur_q.y;
      out_end_q <= out_end_load;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_end_o   = out_end_q;

  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.first) |=> (travelled_q == '0))
    else $error("first point did not clear the travelled distance");

  a_close_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_end_load) |-> cur_q.last)
    else $error("closing copy emitted for a point that is not last");

  a_below_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && !take) |=> (travelled_q < TRAVEL_BITS'(spacing_i)))
    else $error("travelled distance changed on a point that was not kept");

endmodule

// ===== src/path_distance_downsampler.sv =====
// Top level of the path distance downsampler: spacing register, front, queue and back.
//
// Keeps points of a path at a fixed arc-length spacing. Points arrive as signed
// coordinates in units of 1/1024 m, with first and last marks. A first point is
// always sent out; every later point adds the floored Euclidean distance to the
// previous point onto a 40-bit saturating accumulator, and when the accumulator
// reaches the spacing the point is sent out and the spacing is subtracted once.
// A last point is sent out as a closing copy with out_end set, so a final
// point may appear twice. A point without a first mark continues from the stored
// previous point, also right after reset or after a last point. The spacing
// register resets to 410 (0.4 m) and must only be written while no word is in
// flight. Flow control: the front takes a word whenever its two-entry queue has room,
// so up to two words (plus the one being worked on) are absorbed while results
// wait on the output. The back handles one word at a time: a first point goes
// straight to emission; a continuing point passes squaring, the 25-step
// bit-serial square root unit that dominates its cost, accumulation and the
// spacing test. The output word sits in a register held while out_stall_i is high.
module path_distance_downsampler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pdd_pkg::coord_t     pos_x_i,
  input  pdd_pkg::coord_t     pos_y_i,
  input  logic                first_point_i,
  input  logic                last_point_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pdd_pkg::coord_t     out_x_o,
  output pdd_pkg::coord_t     out_y_o,
  output logic                out_end_o,
  input  logic                spacing_we_i,
  input  pdd_pkg::spacing_t   spacing_i
);
  import pdd_pkg::*;

  spacing_t   spacing_q;
  logic       push;
  logic       pop;
  pdd_item_t  push_item;
  pdd_item_t  head_item;
  pdd_qstat_t qstat;

  // Spacing register; the user must write it only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACING_RESET;
    end else if (spacing_we_i) begin
      spacing_q <= spacing_i;
    end
  end

  // The front classifies each word and forms the deltas against the previous point.
  pdd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .first_point_i (first_point_i),
    .last_point_i  (last_point_i),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (push_item)
  );

  // The queue decouples intake from the long per-point distance computation.
  pdd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (pop),
    .rdata_o (head_item),
    .stat_o  (qstat)
  );

  // The back computes the distance, runs the accumulator and emits results.
  pdd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .item_i      (head_item),
    .pop_o       (pop),
    .spacing_i   (spacing_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_end_o   (out_end_o)
  );

endmodule
